// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define FDP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("fdp assertion failed");

// expression must never hold
`define FDP_NEVER(lbl, expr) \
    `FDP_ASSERT(lbl, !(expr))

`endif

// ===== hdl/fdp_pkg.sv =====
// ----------------------------------------------------------------------------
// fdp_pkg
// Types and constants of the 4D point projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package fdp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_WIDTH   = 48;
    localparam int ALPHA_WIDTH = FRAC_BITS + 1;
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int QUO_WIDTH   = OUT_WIDTH;
    localparam int NUM_CELLS   = QUO_WIDTH;
    localparam int LANES       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int LARGE_SCALE = 1000000;

    localparam logic [2:0] MODE_PERSP   = 3'd0;
    localparam logic [2:0] MODE_STEREO  = 3'd1;
    localparam logic [2:0] MODE_ORTHO   = 3'd2;
    localparam logic [2:0] MODE_OBLIQUE = 3'd3;
    localparam logic [2:0] MODE_SLICE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THICK   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE    = 3'd7;

    localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
        logic signed [COORD_WIDTH-1:0] in_w;
    } fdp_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] out_x;
        logic signed [OUT_WIDTH-1:0] out_y;
        logic signed [OUT_WIDTH-1:0] out_z;
        logic [ALPHA_WIDTH-1:0]      alpha;
        logic                        point_valid;
    } fdp_out_t;

    typedef struct packed {
        logic [2:0]                    mode;
        logic signed [COORD_WIDTH-1:0] eye;
        logic signed [COORD_WIDTH-1:0] shear_x;
        logic signed [COORD_WIDTH-1:0] shear_y;
        logic signed [COORD_WIDTH-1:0] shear_z;
        logic signed [COORD_WIDTH-1:0] slice;
        logic [COORD_WIDTH-2:0]        thick;
        logic                          fade;
    } fdp_cfg_t;

    typedef struct packed {
        logic                          add_x;
        logic                          zero_xyz;
        logic                          fade_alpha;
        logic                          reject;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } fdp_side_t;

    typedef struct packed {
        logic [MAG_WIDTH-1:0]   a;
        logic [COORD_WIDTH-1:0] b;
        logic [MAG_WIDTH-1:0]   den;
        logic                   neg;
    } fdp_op_t;

    typedef struct packed {
        fdp_op_t [LANES-1:0] op;
        fdp_side_t           side;
    } fdp_prep_t;

    typedef struct packed {
        logic [PROD_WIDTH-1:0] num;
        logic [MAG_WIDTH-1:0]  den;
        logic                  neg;
    } fdp_prod_t;

    typedef struct packed {
        fdp_prod_t [LANES-1:0] lane;
        fdp_side_t             side;
    } fdp_mul_t;

    typedef struct packed {
        logic [MAG_WIDTH-1:0] den;
        logic [MAG_WIDTH-1:0] rem;
        logic [QUO_WIDTH-1:0] numlo;
        logic [QUO_WIDTH-1:0] quo;
        logic                 ovf;
        logic                 neg;
    } fdp_lane_t;

    typedef struct packed {
        fdp_lane_t [LANES-1:0] lane;
        fdp_side_t             side;
    } fdp_work_t;

endpackage

`default_nettype wire

// ===== hdl/fdp_front.sv =====
// ----------------------------------------------------------------------------
// fdp_front
// Operand selection per mode, then the magnitude multiply; feeds the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fdp_front import fdp_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire fdp_cfg_t  cfg,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire fdp_in_t   s_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output fdp_work_t      out_data
);

    localparam logic [MAG_WIDTH-1:0]   ONE_M = MAG_WIDTH'(1) << FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] ONE_C = COORD_WIDTH'(1) << FRAC_BITS;

    function automatic logic [MAG_WIDTH-1:0] mag_c(input logic signed [COORD_WIDTH-1:0] v);
        logic signed [MAG_WIDTH-1:0] e;
        e = MAG_WIDTH'(v);
        return v[COORD_WIDTH-1] ? MAG_WIDTH'(-e) : MAG_WIDTH'(e);
    endfunction

    function automatic logic [MAG_WIDTH-1:0] mag_d(input logic signed [MAG_WIDTH-1:0] v);
        return v[MAG_WIDTH-1] ? MAG_WIDTH'(-v) : MAG_WIDTH'(v);
    endfunction

    fdp_prep_t prep_reg, prep_next;
    logic      v1_reg;
    fdp_mul_t  mul_reg, mul_next;
    logic      v2_reg;
    logic      rdy1, rdy2;

    logic signed [MAG_WIDTH-1:0]   den_p, den_s, dw;
    logic signed [COORD_WIDTH+1:0] sum;
    logic [MAG_WIDTH-1:0]          dmag;
    logic                          reject;
    logic signed [COORD_WIDTH-1:0] ax [3];
    logic signed [COORD_WIDTH-1:0] sh [3];

    always_comb begin
        ax[0] = s_data.in_x;
        ax[1] = s_data.in_y;
        ax[2] = s_data.in_z;
        sh[0] = cfg.shear_x;
        sh[1] = cfg.shear_y;
        sh[2] = cfg.shear_z;
        den_p = MAG_WIDTH'(cfg.eye) - MAG_WIDTH'(s_data.in_w);
        den_s = $signed(ONE_M) - MAG_WIDTH'(s_data.in_w);
        dw    = MAG_WIDTH'(s_data.in_w) - MAG_WIDTH'(cfg.slice);
        dmag  = mag_d(dw);
        sum   = (COORD_WIDTH+2)'(s_data.in_x) + (COORD_WIDTH+2)'(s_data.in_y)
              + (COORD_WIDTH+2)'(s_data.in_z);
        reject = dmag > MAG_WIDTH'(cfg.thick);

        prep_next = '0;
        prep_next.side.x = s_data.in_x;
        prep_next.side.y = s_data.in_y;
        prep_next.side.z = s_data.in_z;
        prep_next.side.add_x      = (cfg.mode == MODE_OBLIQUE);
        prep_next.side.reject     = (cfg.mode == MODE_SLICE) && reject;
        prep_next.side.zero_xyz   = prep_next.side.reject;
        prep_next.side.fade_alpha = (cfg.mode == MODE_SLICE) && !reject && cfg.fade
                                  && (cfg.thick != '0);
        for (int i = 0; i < 3; i++) begin
            prep_next.op[i].a   = mag_c(ax[i]);
            prep_next.op[i].b   = COORD_WIDTH'(1);
            prep_next.op[i].den = MAG_WIDTH'(1);
            prep_next.op[i].neg = ax[i][COORD_WIDTH-1];
            case (cfg.mode)
                MODE_PERSP: begin
                    if (den_p == '0) begin
                        prep_next.op[i].b = COORD_WIDTH'(LARGE_SCALE);
                    end else begin
                        prep_next.op[i].b   = COORD_WIDTH'(mag_c(cfg.eye));
                        prep_next.op[i].den = mag_d(den_p);
                        prep_next.op[i].neg = ax[i][COORD_WIDTH-1] ^ cfg.eye[COORD_WIDTH-1]
                                            ^ den_p[MAG_WIDTH-1];
                    end
                end
                MODE_STEREO: begin
                    if (den_s == '0) begin
                        prep_next.op[i].a   = ONE_M;
                        prep_next.op[i].b   = COORD_WIDTH'(LARGE_SCALE);
                        prep_next.op[i].neg = sum[COORD_WIDTH+1];
                    end else begin
                        prep_next.op[i].b   = ONE_C;
                        prep_next.op[i].den = mag_d(den_s);
                        prep_next.op[i].neg = ax[i][COORD_WIDTH-1] ^ den_s[MAG_WIDTH-1];
                    end
                end
                MODE_OBLIQUE: begin
                    prep_next.op[i].a   = mag_c(s_data.in_w);
                    prep_next.op[i].b   = COORD_WIDTH'(mag_c(sh[i]));
                    prep_next.op[i].den = ONE_M;
                    prep_next.op[i].neg = sh[i][COORD_WIDTH-1] ^ s_data.in_w[COORD_WIDTH-1];
                end
                default: begin
                end
            endcase
        end
        prep_next.op[3].a   = prep_next.side.fade_alpha ? dmag : '0;
        prep_next.op[3].b   = ONE_C;
        prep_next.op[3].den = prep_next.side.fade_alpha ? MAG_WIDTH'(cfg.thick)
                                                        : MAG_WIDTH'(1);
        prep_next.op[3].neg = 1'b0;
    end

    always_comb begin
        logic [MAG_WIDTH+COORD_WIDTH-1:0] p;
        mul_next.side = prep_reg.side;
        for (int i = 0; i < LANES; i++) begin
            p = prep_reg.op[i].a * prep_reg.op[i].b;
            mul_next.lane[i].num = p[PROD_WIDTH-1:0];
            mul_next.lane[i].den = prep_reg.op[i].den;
            mul_next.lane[i].neg = prep_reg.op[i].neg;
        end
    end

    assign rdy2    = !v2_reg || out_ready;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) prep_reg <= prep_next;
        if (rdy2 && v1_reg) mul_reg <= mul_next;
    end

    always_comb begin
        logic [MAG_WIDTH-1:0] top;
        out_data.side = mul_reg.side;
        for (int i = 0; i < LANES; i++) begin
            top = MAG_WIDTH'(mul_reg.lane[i].num[PROD_WIDTH-1:QUO_WIDTH]);
            out_data.lane[i].den   = mul_reg.lane[i].den;
            out_data.lane[i].ovf   = top >= mul_reg.lane[i].den;
            out_data.lane[i].rem   = top;
            out_data.lane[i].numlo = mul_reg.lane[i].num[QUO_WIDTH-1:0];
            out_data.lane[i].quo   = '0;
            out_data.lane[i].neg   = mul_reg.lane[i].neg;
        end
    end

    assign out_valid = v2_reg;

endmodule

`default_nettype wire

// ===== hdl/fdp_div_cell.sv =====
// ----------------------------------------------------------------------------
// fdp_div_cell
// One restoring-division step: one quotient bit for every lane, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fdp_div_cell import fdp_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire fdp_work_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output fdp_work_t      out_data
);

    fdp_work_t work_reg, work_next;
    logic      valid_reg;

    always_comb begin
        logic [MAG_WIDTH:0] r2;
        logic [MAG_WIDTH:0] diff;
        logic               ge;
        work_next = in_data;
        for (int i = 0; i < LANES; i++) begin
            r2   = {in_data.lane[i].rem, in_data.lane[i].numlo[QUO_WIDTH-1]};
            diff = r2 - {1'b0, in_data.lane[i].den};
            ge   = r2 >= {1'b0, in_data.lane[i].den};
            work_next.lane[i].rem   = ge ? diff[MAG_WIDTH-1:0] : r2[MAG_WIDTH-1:0];
            work_next.lane[i].numlo = in_data.lane[i].numlo << 1;
            work_next.lane[i].quo   = {in_data.lane[i].quo[QUO_WIDTH-2:0], ge};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = work_reg;

endmodule

`default_nettype wire

// ===== hdl/fdp_back.sv =====
// ----------------------------------------------------------------------------
// fdp_back
// Sign, shear offset, saturation and alpha; holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module fdp_back import fdp_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire fdp_work_t in_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output fdp_out_t       m_data
);

    localparam int EW = OUT_WIDTH + 2;
    localparam logic signed [EW-1:0] SAT_HI = EW'((64'(1) << (OUT_WIDTH - 1)) - 1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    fdp_out_t out_reg, out_next;
    logic     valid_reg;
    logic signed [OUT_WIDTH-1:0] res [3];

    always_comb begin
        logic signed [EW-1:0] qs;
        logic signed [COORD_WIDTH-1:0] base;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0:       base = in_data.side.x;
                1:       base = in_data.side.y;
                default: base = in_data.side.z;
            endcase
            qs = $signed({2'b00, in_data.lane[i].quo});
            if (in_data.lane[i].neg) qs = -qs;
            if (in_data.side.add_x) qs = qs + EW'(base);
            if (in_data.lane[i].ovf) begin
                res[i] = in_data.lane[i].neg ? OUT_WIDTH'(SAT_LO) : OUT_WIDTH'(SAT_HI);
            end else if (qs > SAT_HI) begin
                res[i] = OUT_WIDTH'(SAT_HI);
            end else if (qs < SAT_LO) begin
                res[i] = OUT_WIDTH'(SAT_LO);
            end else begin
                res[i] = qs[OUT_WIDTH-1:0];
            end
            if (in_data.side.zero_xyz) res[i] = '0;
        end
        out_next.out_x = res[0];
        out_next.out_y = res[1];
        out_next.out_z = res[2];
        if (in_data.side.fade_alpha) begin
            out_next.alpha = ALPHA_ONE - in_data.lane[3].quo[ALPHA_WIDTH-1:0];
        end else begin
            out_next.alpha = in_data.side.reject ? '0 : ALPHA_ONE;
        end
        out_next.point_valid = !in_data.side.reject;
    end

    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) out_reg <= out_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== hdl/four_d_point_projection.sv =====
// ----------------------------------------------------------------------------
// four_d_point_projection
// Projects one Q16.16 4D point per word to a saturated Q32.16 3D point.
// ----------------------------------------------------------------------------
// Input words arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data, one result word per input word, in order.
// Registers are written through cfg_wr_en/cfg_index/cfg_data while idle;
// the user must keep to that, the block itself does not enforce it.
// Each word passes through 51 registered stages: operand select, multiply,
// 48 divider cells (one quotient bit each), output register; the accepting
// edge loads the first. Throughput is one word per cycle while m_ready is
// high; the divider chain is fully pipelined, each stage holding its own word.
// A stalled receiver holds the output word; upstream stages keep filling
// empty slots, so s_ready drops only once every stage holds a word.
// Synchronous reset empties the pipeline and loads register defaults:
// perspective mode, eye distance 2.0, slab half width 1.0, others zero.
// ----------------------------------------------------------------------------
`default_nettype none

module four_d_point_projection import fdp_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COORD_WIDTH-1:0] cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire fdp_in_t                s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output fdp_out_t                    m_data
);

    `include "assert_macros.svh"

    fdp_cfg_t  cfg_reg;
    fdp_work_t cell_data  [NUM_CELLS+1];
    logic      cell_valid [NUM_CELLS+1];
    logic      cell_ready [NUM_CELLS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode:    MODE_PERSP,
                         eye:     COORD_WIDTH'(2) << FRAC_BITS,
                         shear_x: '0,
                         shear_y: '0,
                         shear_z: '0,
                         slice:   '0,
                         thick:   (COORD_WIDTH-1)'(1) << FRAC_BITS,
                         fade:    1'b0};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE:    cfg_reg.mode    <= cfg_data[2:0];
                CFG_EYE:     cfg_reg.eye     <= cfg_data;
                CFG_SHEAR_X: cfg_reg.shear_x <= cfg_data;
                CFG_SHEAR_Y: cfg_reg.shear_y <= cfg_data;
                CFG_SHEAR_Z: cfg_reg.shear_z <= cfg_data;
                CFG_SLICE:   cfg_reg.slice   <= cfg_data;
                CFG_THICK:   cfg_reg.thick   <= cfg_data[COORD_WIDTH-2:0];
                CFG_FADE:    cfg_reg.fade    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    fdp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_valid (cell_valid[0]),
        .out_ready (cell_ready[0]),
        .out_data  (cell_data[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        fdp_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[k]),
            .in_ready  (cell_ready[k]),
            .in_data   (cell_data[k]),
            .out_valid (cell_valid[k+1]),
            .out_ready (cell_ready[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    fdp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cell_valid[NUM_CELLS]),
        .in_ready (cell_ready[NUM_CELLS]),
        .in_data  (cell_data[NUM_CELLS]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `FDP_ASSERT(a_reject_zero, m_valid && !m_data.point_valid |-> (m_data.alpha == '0 && m_data.out_x == '0 && m_data.out_y == '0 && m_data.out_z == '0))
    `FDP_NEVER(a_alpha_range, m_valid && (m_data.alpha > ALPHA_ONE))
    `FDP_ASSERT(a_full_stall, !s_ready |-> (m_valid && !m_ready))

endmodule

`default_nettype wire
